@@ hw/rtl/multichannel_pulse_width_capture_unit_assert.svh @@
// Assertion macros for the pulse width capture unit.
// Used by the checker; no other dependencies.
`ifndef MULTICHANNEL_PULSE_WIDTH_CAPTURE_UNIT_ASSERT_SVH
`define MULTICHANNEL_PULSE_WIDTH_CAPTURE_UNIT_ASSERT_SVH

// Checked on every rising clock edge outside reset
`define MPWC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// Checked on every rising clock edge, reset included
`define MPWC_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

@@ hw/rtl/mpwc_pkg.sv @@
// Shared constants and types for the pulse width capture unit.
// No dependencies.
package mpwc_pkg;

  localparam int unsigned NumChannels = 8;
  localparam int unsigned ChanBits    = $clog2(NumChannels);
  localparam int unsigned TimerBits   = 16;

  typedef logic [NumChannels-1:0] chan_mask_t;
  typedef logic [ChanBits-1:0]    chan_idx_t;
  typedef logic [TimerBits-1:0]   timer_t;

  // All channels enabled out of reset
  localparam chan_mask_t EnableReset = '1;

endpackage

@@ hw/rtl/mpwc_evt_if.sv @@
// Pin-change event channel: valid/ready handshake with levels and timestamp.
// Depends on mpwc_pkg.
interface mpwc_evt_if import mpwc_pkg::*; ();
  logic       valid;
  logic       ready;
  chan_mask_t pin_levels;
  timer_t     timestamp;

  modport source (output valid, output pin_levels, output timestamp, input ready);
  modport sink   (input valid, input pin_levels, input timestamp, output ready);
endinterface

@@ hw/rtl/mpwc_res_if.sv @@
// Width result channel: valid/ready handshake with channel, width, last flag.
// Depends on mpwc_pkg.
interface mpwc_res_if import mpwc_pkg::*; ();
  logic      valid;
  logic      ready;
  chan_idx_t channel_index;
  timer_t    pulse_width;
  logic      last_of_run;

  modport source (output valid, output channel_index, output pulse_width,
                  output last_of_run, input ready);
  modport sink   (input valid, input channel_index, input pulse_width,
                  input last_of_run, output ready);
endinterface

@@ hw/rtl/multichannel_pulse_width_capture_unit.sv @@
// Pulse width capture, 8 channels. Rise times live in an 8 x 16 RAM.
// Path: the scan reaches channel n, then its width goes through the read stage
//   and the output register. A new event is taken only once the scan is done;
//   the scan visits every channel, one RAM read/write per cycle when not stalled.
// Reset: async, active low; clears levels, enable mask to all-ones, and the
//   per-entry valid bits so unwritten rise times read as zero.
module multichannel_pulse_width_capture_unit import mpwc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  chan_mask_t cfg_wdata_i,
  mpwc_evt_if.sink   evt,
  mpwc_res_if.source res
);

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StScan = 2'b10
  } state_e;

  localparam chan_idx_t LastChan = chan_idx_t'(NumChannels - 1);

  state_e     state_q, state_d;
  chan_idx_t  ch_q, ch_d;
  chan_mask_t enable_q, prior_q, rises_q, falls_q, entry_valid_q;
  timer_t     stamp_q;

  logic       s1_valid_q, s1_last_q;
  chan_idx_t  s1_ch_q;
  timer_t     rd_q;
  logic       rd_valid_q;

  logic       out_valid_q, out_last_q;
  chan_idx_t  out_ch_q;
  timer_t     out_width_q;

  timer_t     rise_mem [NumChannels];

  logic       evt_fire, adv, scan_act;
  chan_mask_t changed;
  timer_t     rise_time;

  // Handshake and pipeline advance
  assign evt.ready = (state_q == StIdle) && !s1_valid_q;
  assign evt_fire  = evt.valid && evt.ready;
  assign adv       = !out_valid_q || res.ready;
  assign scan_act  = (state_q == StScan) && adv;
  assign changed   = (evt.pin_levels ^ prior_q) & enable_q;

  // Scan sequencer
  always_comb begin
    state_d = state_q;
    ch_d    = ch_q;
    unique case (state_q)
      StIdle: begin
        if (evt_fire) begin
          state_d = StScan;
          ch_d    = '0;
        end
      end
      StScan: begin
        if (adv) begin
          ch_d = ch_q + chan_idx_t'(1);
          if (ch_q == LastChan) begin
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      ch_q     <= '0;
      enable_q <= EnableReset;
      prior_q  <= '0;
      rises_q  <= '0;
      falls_q  <= '0;
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
      if (cfg_we_i) begin
        enable_q <= cfg_wdata_i;
      end
      if (evt_fire) begin
        prior_q <= evt.pin_levels;
        rises_q <= changed & evt.pin_levels;
        falls_q <= changed & ~evt.pin_levels;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt_fire) begin
      stamp_q <= evt.timestamp;
    end
  end

  // Rise time RAM: write on rising edge, registered read for falling edge
  always_ff @(posedge clk_i) begin
    if (scan_act && rises_q[ch_q]) begin
      rise_mem[ch_q] <= stamp_q;
    end
    if (scan_act) begin
      rd_q <= rise_mem[ch_q];
    end
  end

  // Written-entry flags stand in for clearing the RAM
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_valid_q <= '0;
      rd_valid_q    <= 1'b0;
    end else if (scan_act) begin
      if (rises_q[ch_q]) begin
        entry_valid_q[ch_q] <= 1'b1;
      end
      rd_valid_q <= entry_valid_q[ch_q];
    end
  end

  // Read stage: marks which channel has a falling edge
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= (state_q == StScan) && falls_q[ch_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_ch_q   <= ch_q;
      s1_last_q <= ((falls_q >> ch_q) >> 1) == '0;
    end
  end

  // Output register
  assign rise_time = rd_valid_q ? rd_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_valid_q) begin
      out_ch_q    <= s1_ch_q;
      out_width_q <= stamp_q - rise_time;
      out_last_q  <= s1_last_q;
    end
  end

  assign res.valid         = out_valid_q;
  assign res.channel_index = out_ch_q;
  assign res.pulse_width   = out_width_q;
  assign res.last_of_run   = out_last_q;

endmodule

@@ hw/rtl/mpwc_checker.sv @@
// Port-level checks for the pulse width capture unit, bound to the top level.
// Depends on mpwc_pkg and the assertion macro header.
`include "multichannel_pulse_width_capture_unit_assert.svh"

module mpwc_checker import mpwc_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      evt_valid_i,
  input logic      evt_ready_i,
  input logic      res_valid_i,
  input logic      res_ready_i,
  input chan_idx_t res_channel_index_i,
  input timer_t    res_pulse_width_i,
  input logic      res_last_of_run_i
);

  logic      evt_fire, res_fire;
  logic      run_open_q;
  chan_idx_t prev_idx_q;

  assign evt_fire = evt_valid_i && evt_ready_i;
  assign res_fire = res_valid_i && res_ready_i;

  // Track the open run of results from one event
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_open_q <= 1'b0;
      prev_idx_q <= '0;
    end else if (res_fire) begin
      run_open_q <= !res_last_of_run_i;
      prev_idx_q <= res_channel_index_i;
    end
  end

  // Stalled result holds
  `MPWC_ASSERT(a_res_hold, clk_i, rst_ni, res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_channel_index_i) && $stable(res_pulse_width_i) && $stable(res_last_of_run_i))

  // Results within a run come out in ascending channel order
  `MPWC_ASSERT(a_ascending, clk_i, rst_ni, res_fire && run_open_q |-> res_channel_index_i > prev_idx_q)

  // No new event while a non-final result is waiting
  `MPWC_ASSERT(a_no_overlap, clk_i, rst_ni, evt_fire |-> !(res_valid_i && !res_last_of_run_i))

  // One event at a time
  `MPWC_ASSERT(a_busy_after_evt, clk_i, rst_ni, evt_fire |=> !evt_ready_i)

  // Nothing offered right out of reset
  `MPWC_ASSERT_NR(a_reset_quiet, clk_i, $rose(rst_ni) |-> !res_valid_i)

endmodule

bind multichannel_pulse_width_capture_unit mpwc_checker u_mpwc_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .evt_valid_i         (evt.valid),
  .evt_ready_i         (evt.ready),
  .res_valid_i         (res.valid),
  .res_ready_i         (res.ready),
  .res_channel_index_i (res.channel_index),
  .res_pulse_width_i   (res.pulse_width),
  .res_last_of_run_i   (res.last_of_run)
);

@@ tb/sv/tb_multichannel_pulse_width_capture_unit.sv @@
// Testbench for the eight-channel pulse width capture unit: directed and random
// pin-change transactions are checked against an in-bench width predictor.
// Depends on mpwc_pkg, mpwc_evt_if, mpwc_res_if and the unit itself.
module tb_multichannel_pulse_width_capture_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import mpwc_pkg::*;

  localparam int unsigned SettleCycles = 16;    // scan of all channels plus drain
  localparam int unsigned StallLimit   = 3000;  // cycles with no transaction
  localparam int unsigned HoldCycles   = 300;   // long receiver hold-off

  typedef struct packed {
    chan_idx_t chan;
    timer_t    width;
    logic      last;
  } width_rec_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  chan_mask_t cfg_wdata_i;

  mpwc_evt_if evt_bus ();
  mpwc_res_if res_bus ();

  multichannel_pulse_width_capture_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .evt        (evt_bus),
    .res        (res_bus)
  );

  // Predictor state
  chan_mask_t enable_mask;
  chan_mask_t seen_levels;
  timer_t     rise_stamp [NumChannels];
  width_rec_t width_q [$];

  int unsigned err_cnt;
  int unsigned idle_cnt;
  int unsigned hold_len;
  bit          idle_on;
  timer_t      last_stamp;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Expected widths for one accepted event, in ascending channel order
  task automatic predict_widths(input chan_mask_t lv, input timer_t ts);
    chan_mask_t changed;
    chan_mask_t falls;
    int         last_ch;
    width_rec_t rec;
    changed = (lv ^ seen_levels) & enable_mask;
    falls   = changed & ~lv;
    seen_levels = lv;
    last_ch = -1;
    for (int n = 0; n < NumChannels; n++) begin
      if (falls[n]) last_ch = n;
    end
    for (int n = 0; n < NumChannels; n++) begin
      if (changed[n] && lv[n]) begin
        rise_stamp[n] = ts;
      end else if (changed[n]) begin
        rec.chan  = chan_idx_t'(n);
        rec.width = timer_t'(ts - rise_stamp[n]);
        rec.last  = (n == last_ch);
        width_q.push_back(rec);
      end
    end
  endtask

  // One event transaction; valid stays high on return
  task automatic send_event(input chan_mask_t lv, input timer_t ts);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      evt_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    evt_bus.valid      <= 1'b1;
    evt_bus.pin_levels <= lv;
    evt_bus.timestamp  <= ts;
    do @(posedge clk_i); while (!evt_bus.ready);
    last_stamp = ts;
    predict_widths(lv, ts);
  endtask

  // Stop sending and let every expected width come out
  task automatic wait_idle();
    evt_bus.valid <= 1'b0;
    while (width_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_channel_mask(input chan_mask_t m);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    enable_mask = m;
  endtask

  // Receiver: random stalls per result, plus a long hold-off on request
  initial begin
    int unsigned stall;
    int unsigned hold;
    res_bus.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      hold = hold_len;
      hold_len = 0;
      stall = idle_on ? $urandom_range(0, 3) : 0;
      if (hold + stall > 0) begin
        res_bus.ready <= 1'b0;
        repeat (hold + stall) @(posedge clk_i);
      end
      res_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!res_bus.valid);
    end
  end

  // Result checker
  always @(posedge clk_i) begin : check_widths
    width_rec_t exp_rec;
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      if (width_q.size() == 0) begin
        $error("unexpected width: channel_index %0d pulse_width %0d last_of_run %0b",
               res_bus.channel_index, res_bus.pulse_width, res_bus.last_of_run);
        err_cnt++;
      end else begin
        exp_rec = width_q.pop_front();
        if (res_bus.channel_index !== exp_rec.chan) begin
          $error("channel_index: expected %0d, got %0d", exp_rec.chan,
                 res_bus.channel_index);
          err_cnt++;
        end
        if (res_bus.pulse_width !== exp_rec.width) begin
          $error("pulse_width: expected %0d, got %0d", exp_rec.width, res_bus.pulse_width);
          err_cnt++;
        end
        if (res_bus.last_of_run !== exp_rec.last) begin
          $error("last_of_run: expected %0b, got %0b", exp_rec.last, res_bus.last_of_run);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (!rst_ni || (evt_bus.valid && evt_bus.ready) || (res_bus.valid && res_bus.ready)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= StallLimit) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  // Fall with no rise seen: against the reset value and a time kept while disabled
  task automatic test_fall_without_rise();
    idle_on = 1'b0;
    set_channel_mask(8'hFE);
    send_event(8'h01, 16'h0777);
    set_channel_mask(8'hFF);
    send_event(8'h00, 16'h0042);
    send_event(8'h02, 16'h0100);
    set_channel_mask(8'hFD);
    send_event(8'h00, 16'h0200);
    send_event(8'h02, 16'h0300);
    set_channel_mask(8'hFF);
    send_event(8'h00, 16'h0450);
  endtask

  // All channels at once, timer wrap, mixed rise and fall, no change
  task automatic test_all_channels_wrap();
    idle_on = 1'b1;
    send_event(8'hFF, 16'h0010);
    send_event(8'h00, 16'h0005);
    send_event(8'hAA, 16'hFFFF);
    send_event(8'h55, 16'h0000);
    send_event(8'h00, 16'hFFFF);
    send_event(8'h00, 16'h1234);
  endtask

  // Enable mask at none, a single high channel and a single low channel
  task automatic test_mask_extremes();
    idle_on = 1'b1;
    set_channel_mask(8'h00);
    send_event(8'hFF, 16'h1111);
    send_event(8'h00, 16'h2222);
    send_event(8'hFF, 16'h3333);
    set_channel_mask(8'h80);
    send_event(8'h7F, 16'h4000);
    send_event(8'hFF, 16'h5000);
    send_event(8'h00, 16'h5ABC);
    set_channel_mask(8'h01);
    send_event(8'h01, 16'h8000);
    send_event(8'hFE, 16'h8123);
    set_channel_mask(8'hFF);
  endtask

  // Receiver holds off while the sender keeps offering full-width events
  task automatic test_backpressure();
    wait_idle();
    idle_on = 1'b0;
    hold_len = HoldCycles;
    for (int i = 0; i < 24; i++) begin
      send_event((i % 2 == 0) ? 8'hFF : 8'h00, timer_t'(last_stamp + $urandom_range(1, 500)));
    end
  endtask

  // Sender pauses mid-stream until every width is out, then resumes
  task automatic test_drain_pause();
    idle_on = 1'b1;
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 4; i++) begin
        send_event(chan_mask_t'($urandom()), timer_t'($urandom()));
      end
      wait_idle();
    end
  endtask

  // Random pin activity: mostly sparse toggles on a rising timer, some noise
  task automatic run_random_phase(input int unsigned n_items, input chan_mask_t m,
                                  input bit idle);
    chan_mask_t lv;
    timer_t     ts;
    int unsigned kind;
    set_channel_mask(m);
    idle_on = idle;
    for (int unsigned i = 0; i < n_items; i++) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        lv = chan_mask_t'($urandom());
        ts = timer_t'($urandom());
      end else if (kind < 4) begin
        lv = seen_levels ^ chan_mask_t'(1 << $urandom_range(0, NumChannels - 1));
        ts = timer_t'(last_stamp + $urandom_range(1, 4000));
      end else begin
        lv = seen_levels ^ chan_mask_t'($urandom() & $urandom());
        ts = timer_t'(last_stamp + $urandom_range(0, 20000));
      end
      send_event(lv, ts);
    end
  endtask

  task automatic test_random_traffic();
    run_random_phase(100, 8'hFF, 1'b1);
    run_random_phase(80, chan_mask_t'($urandom()), 1'b0);
    run_random_phase(20, 8'h00, 1'b1);
    run_random_phase(80, chan_mask_t'($urandom()), 1'b1);
    run_random_phase(60, chan_mask_t'(1 << $urandom_range(0, NumChannels - 1)), 1'b1);
    run_random_phase(100, 8'hFF, 1'b1);
  endtask

  initial begin
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_wdata_i        <= '0;
    evt_bus.valid      <= 1'b0;
    evt_bus.pin_levels <= '0;
    evt_bus.timestamp  <= '0;
    enable_mask = EnableReset;
    seen_levels = '0;
    for (int n = 0; n < NumChannels; n++) rise_stamp[n] = '0;
    hold_len   = 0;
    idle_on    = 1'b0;
    last_stamp = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_fall_without_rise();
    test_all_channels_wrap();
    test_mask_extremes();
    test_backpressure();
    test_drain_pause();
    test_random_traffic();

    wait_idle();
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ multichannel_pulse_width_capture_unit.f @@
+incdir+hw/rtl
hw/rtl/mpwc_pkg.sv
hw/rtl/mpwc_evt_if.sv
hw/rtl/mpwc_res_if.sv
hw/rtl/multichannel_pulse_width_capture_unit.sv
hw/rtl/mpwc_checker.sv
tb/sv/tb_multichannel_pulse_width_capture_unit.sv
